@@ design/sdmm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmm_pkg: shared types and defaults for the sparse-dense matrix multiply
// Request codes, sequencer states, field widths and default dimensions.
// ----------------------------------------------------------------------------
package sdmm_pkg;

  // Default dimensions and operand widths
  localparam int ROWS_DEF       = 16;
  localparam int INNER_DEF      = 16;
  localparam int COLS_DEF       = 16;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF  = 32;

  // Fixed widths of the request and result fields
  localparam int IDX_W    = 4;
  localparam int IN_VAL_W = 16;
  localparam int OUT_W    = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 32;

  // Request kinds carried on in_tuser
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_APPLY = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APPLY,
    ST_RESP
  } state_t;

endpackage

@@ design/sparse_dense_matrix_multiply.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_dense_matrix_multiply: dense A times sparse B in coordinate form
// Holds A and the accumulators C in on-chip memories; one shared
// multiply-accumulate unit walks the rows of A for every non-zero of B.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A load writes the dense memory as it is
// taken. An apply of an in-range non-zero streams one row per cycle through
// a single multiplier and adder (read, multiply, write back), then drains
// the two stages. A read waits in the response state for the result register
// to empty; a new request may be taken while the result is still waiting. A
// clear request, and the reset itself, run a clearing pass over all ROWS *
// COLS accumulator entries, one entry per cycle, during which no request is
// taken. Out-of-range loads and applies are dropped; an out-of-range read
// returns zero.
module sparse_dense_matrix_multiply #(
  parameter int ROWS       = sdmm_pkg::ROWS_DEF,
  parameter int INNER      = sdmm_pkg::INNER_DEF,
  parameter int COLS       = sdmm_pkg::COLS_DEF,
  parameter int DATA_WIDTH = sdmm_pkg::DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = sdmm_pkg::ACC_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: row_index[3:0], inner_index[7:4], col_index[11:8],
  //        data_value[27:12], zero fill[31:28]
  input  logic [sdmm_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]                         in_tuser,
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata: out_value[31:0]
  output logic [sdmm_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int DENSE_DEPTH = ROWS * INNER;
  localparam int ACC_DEPTH   = ROWS * COLS;
  localparam int DAW  = (DENSE_DEPTH > 1) ? $clog2(DENSE_DEPTH) : 1;
  localparam int AW   = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
  localparam int RCW  = $clog2(ROWS + 1);
  localparam int PW   = 2 * DATA_WIDTH;
  localparam int PEW  = (PW > ACC_WIDTH) ? PW : ACC_WIDTH;
  localparam int VEW  = (DATA_WIDTH > sdmm_pkg::IN_VAL_W) ? DATA_WIDTH : sdmm_pkg::IN_VAL_W;
  localparam int OEW  = (ACC_WIDTH > sdmm_pkg::OUT_W) ? ACC_WIDTH : sdmm_pkg::OUT_W;

  // Request fields
  logic                                 in_accept;
  sdmm_pkg::req_t                       req_type;
  logic [sdmm_pkg::IDX_W-1:0]           row_index;
  logic [sdmm_pkg::IDX_W-1:0]           inner_index;
  logic [sdmm_pkg::IDX_W-1:0]           col_index;
  logic signed [sdmm_pkg::IN_VAL_W-1:0] data_value;
  logic signed [DATA_WIDTH-1:0]         val_op;
  logic                                 load_ok;
  logic                                 apply_ok;
  logic                                 read_ok;

  // Sequencer
  sdmm_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r;
  logic             clr_last;
  logic [RCW-1:0]   iss_cnt_r;
  logic             issue;
  logic             v1_r, v2_r;
  logic             apply_done;
  logic             out_free;

  // Datapath registers
  logic [DAW-1:0]                d_addr_r;
  logic [AW-1:0]                 a_addr_r;
  logic [AW-1:0]                 wa1_r, wa2_r;
  logic signed [DATA_WIDTH-1:0]  val_r;
  logic signed [PW-1:0]          prod_r;
  logic [ACC_WIDTH-1:0]          accq_r;
  logic                          rd_ok_r;
  logic                          out_tvalid_r;
  logic [sdmm_pkg::OUT_W-1:0]    out_tdata_r;
  logic [sdmm_pkg::OUT_W-1:0]    out_value;

  // Memories and their ports
  logic [DATA_WIDTH-1:0]        dense_mem [DENSE_DEPTH];
  logic [ACC_WIDTH-1:0]         acc_mem   [ACC_DEPTH];
  logic signed [DATA_WIDTH-1:0] dense_rd_r;
  logic signed [ACC_WIDTH-1:0]  acc_rd_r;
  logic                         dense_we;
  logic [DAW-1:0]               dense_wa;
  logic                         acc_we;
  logic [AW-1:0]                acc_wa;
  logic [ACC_WIDTH-1:0]         acc_wd;
  logic                         acc_re;
  logic [AW-1:0]                acc_ra;
  logic [ACC_WIDTH-1:0]         acc_sum;

  // Unpack the request and check its indexes
  assign in_accept   = in_tvalid && in_tready;
  assign req_type    = sdmm_pkg::req_t'(in_tuser);
  assign row_index   = in_tdata[3:0];
  assign inner_index = in_tdata[7:4];
  assign col_index   = in_tdata[11:8];
  assign data_value  = in_tdata[27:12];
  assign val_op      = DATA_WIDTH'(VEW'(data_value));
  assign load_ok     = (32'(row_index) < ROWS) && (32'(inner_index) < INNER);
  assign apply_ok    = (32'(inner_index) < INNER) && (32'(col_index) < COLS);
  assign read_ok     = (32'(row_index) < ROWS) && (32'(col_index) < COLS);

  // Sequencer status
  assign clr_last   = (clr_addr_r == AW'(ACC_DEPTH - 1));
  assign issue      = (state_r == sdmm_pkg::ST_APPLY) && (iss_cnt_r != RCW'(ROWS));
  assign apply_done = (state_r == sdmm_pkg::ST_APPLY) && !issue && !v1_r && !v2_r;
  assign out_free   = !out_tvalid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdmm_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = sdmm_pkg::ST_IDLE;
      end
      sdmm_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (req_type)
            sdmm_pkg::REQ_APPLY: if (apply_ok) state_nxt = sdmm_pkg::ST_APPLY;
            sdmm_pkg::REQ_READ:  state_nxt = sdmm_pkg::ST_RESP;
            sdmm_pkg::REQ_CLEAR: state_nxt = sdmm_pkg::ST_CLEAR;
            default:             state_nxt = sdmm_pkg::ST_IDLE;
          endcase
        end
      end
      sdmm_pkg::ST_APPLY: begin
        if (apply_done) state_nxt = sdmm_pkg::ST_IDLE;
      end
      sdmm_pkg::ST_RESP: begin
        if (out_free) state_nxt = sdmm_pkg::ST_IDLE;
      end
      default: state_nxt = sdmm_pkg::ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer: handshake and memory port controls
  assign acc_sum = accq_r + ACC_WIDTH'(PEW'(prod_r));

  always_comb begin
    in_tready = (state_r == sdmm_pkg::ST_IDLE);
    dense_we  = in_accept && (req_type == sdmm_pkg::REQ_LOAD) && load_ok;
    dense_wa  = DAW'(32'(row_index) * INNER + 32'(inner_index));
    acc_we    = 1'b0;
    acc_wa    = clr_addr_r;
    acc_wd    = '0;
    acc_re    = 1'b0;
    acc_ra    = a_addr_r;
    if (state_r == sdmm_pkg::ST_CLEAR) begin
      acc_we = 1'b1;
    end else if (v2_r) begin
      acc_we = 1'b1;
      acc_wa = wa2_r;
      acc_wd = acc_sum;
    end
    if (issue) begin
      acc_re = 1'b1;
    end else if (in_accept && (req_type == sdmm_pkg::REQ_READ) && read_ok) begin
      acc_re = 1'b1;
      acc_ra = AW'(32'(row_index) * COLS + 32'(col_index));
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sdmm_pkg::ST_CLEAR;
      clr_addr_r   <= '0;
      iss_cnt_r    <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      // sweep the accumulators, restart on a clear request
      if (state_r == sdmm_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end else if (in_accept && (req_type == sdmm_pkg::REQ_CLEAR)) begin
        clr_addr_r <= '0;
      end
      // count rows sent into the multiply-accumulate pipe
      if (in_accept && (req_type == sdmm_pkg::REQ_APPLY)) begin
        iss_cnt_r <= '0;
      end else if (issue) begin
        iss_cnt_r <= iss_cnt_r + RCW'(1);
      end
      // hold the result until it is taken
      if ((state_r == sdmm_pkg::ST_RESP) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  assign out_value = rd_ok_r ? sdmm_pkg::OUT_W'(OEW'(acc_rd_r)) : '0;

  always_ff @(posedge clk) begin
    // latch operands of an apply request, then advance one row per issue
    if (in_accept && (req_type == sdmm_pkg::REQ_APPLY)) begin
      d_addr_r <= DAW'(inner_index);
      a_addr_r <= AW'(col_index);
      val_r    <= val_op;
    end else if (issue) begin
      d_addr_r <= d_addr_r + DAW'(INNER);
      a_addr_r <= a_addr_r + AW'(COLS);
    end
    if (in_accept && (req_type == sdmm_pkg::REQ_READ)) begin
      rd_ok_r <= read_ok;
    end
    // multiply stage, then write-back stage
    wa1_r  <= a_addr_r;
    wa2_r  <= wa1_r;
    prod_r <= PW'(dense_rd_r) * PW'(val_r);
    accq_r <= acc_rd_r;
    if ((state_r == sdmm_pkg::ST_RESP) && out_free) begin
      out_tdata_r <= out_value;
    end
  end

  // Dense operand memory
  always_ff @(posedge clk) begin
    if (dense_we) dense_mem[dense_wa] <= DATA_WIDTH'(val_op);
    if (issue) dense_rd_r <= dense_mem[d_addr_r];
  end

  // Accumulator memory
  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    if (acc_re) acc_rd_r <= acc_mem[acc_ra];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ design/sdmm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmm_checker: port-level checks for the sparse-dense matrix multiply
// Watches the request and result channels and flags sequencing slips.
// ----------------------------------------------------------------------------
module sdmm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [1:0]                       in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sdmm_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Block requests at the start of the clearing pass after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request taken right after reset");

  // Start a clearing pass on a clear request
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == sdmm_pkg::REQ_CLEAR) |=> !in_tready)
    else $error("request taken right after clear");

  // Stay busy while a read is answered
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == sdmm_pkg::REQ_READ) |=> !in_tready)
    else $error("request taken while a read is answered");

endmodule

bind sparse_dense_matrix_multiply sdmm_checker u_sdmm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
